// File: design/llttc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llttc_pkg
// Types and fixed constants shared by the lane time-to-collision block.
// ----------------------------------------------------------------------------
package llttc_pkg;

    localparam int LANE_BITS      = 17;
    localparam int INTERVAL_BITS  = 20;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 20;
    localparam int TTC_BITS       = 32;
    localparam int STATUS_BITS    = 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_LANE_HALF_WIDTH = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_INTERVAL  = 2'd1;

    localparam logic [LANE_BITS-1:0]     LANE_RESET     = 17'd4000;
    localparam logic [INTERVAL_BITS-1:0] INTERVAL_RESET = 20'd100000;

    localparam logic [STATUS_BITS-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_NO_PREV    = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_NO_LANE    = 2'd2;
    localparam logic [STATUS_BITS-1:0] STATUS_ZERO_CLOSE = 2'd3;

    // Quotient magnitudes at the edges of the signed 32-bit range.
    localparam logic [TTC_BITS:0]   TTC_POS_MAG   = 33'h0_7FFF_FFFF;
    localparam logic [TTC_BITS:0]   TTC_NEG_MAG   = 33'h0_8000_0000;
    localparam logic [TTC_BITS-1:0] TTC_POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [TTC_BITS-1:0] TTC_NEG_LIMIT = 32'h8000_0000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic take_point;
        logic frame_close;
        logic mul_load;
        logic div_step;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic need_div;
    } dp_stat_t;

endpackage
`default_nettype wire

// File: design/llttc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llttc_ctrl
// Sequencer: takes points, then runs multiply, divide (when needed) and
// result load at the end of each frame.
// ----------------------------------------------------------------------------
module llttc_ctrl #(
    parameter int DIV_STEPS = 37
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                frame_end,
    output logic                in_ready,
    input  logic                out_ready,
    output logic                out_valid,
    input  llttc_pkg::dp_stat_t stat,
    output llttc_pkg::dp_cmd_t  cmd
);
    import llttc_pkg::*;

    localparam int CNTW = $clog2(DIV_STEPS + 1);

    ctrl_state_t     state_reg, state_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            out_valid_reg, out_valid_next;
    logic            slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && frame_end)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = stat.need_div ? ST_DIV : ST_OUT;
            end
            ST_DIV:
            begin
                if (cnt_reg == CNTW'(1))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready        = 1'b1;
                cmd.take_point  = in_valid;
                cmd.frame_close = in_valid && frame_end;
            end
            ST_MUL:
            begin
                cmd.mul_load = 1'b1;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_OUT:
            begin
                cmd.out_load = slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (state_reg == ST_MUL)
        begin
            cnt_next = CNTW'(DIV_STEPS);
        end
        else if (state_reg == ST_DIV)
        begin
            cnt_next = cnt_reg - CNTW'(1);
        end
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

// File: design/llttc_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llttc_dp
// Datapath: configuration registers, lane minimum tracking, frame
// snapshot, multiplier, restoring divider and saturating result register.
// ----------------------------------------------------------------------------
module llttc_dp #(
    parameter int COORD_BITS = 18
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  llttc_pkg::dp_cmd_t                      cmd,
    output llttc_pkg::dp_stat_t                     stat,
    input  logic                                    cfg_we,
    input  logic [llttc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [llttc_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  logic signed [COORD_BITS-1:0]            forward_mm,
    input  logic signed [COORD_BITS-1:0]            lateral_mm,
    output logic signed [llttc_pkg::TTC_BITS-1:0]   ttc_us,
    output logic [llttc_pkg::STATUS_BITS-1:0]       status
);
    import llttc_pkg::*;

    localparam int NMAG = COORD_BITS + INTERVAL_BITS - 1;
    localparam int DMAG = COORD_BITS;
    localparam int CMPW = ((COORD_BITS > LANE_BITS) ? COORD_BITS : LANE_BITS) + 1;
    localparam int SATW = (NMAG > TTC_BITS + 1) ? NMAG : TTC_BITS + 1;
    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

    // Configuration.
    logic [LANE_BITS-1:0]     lane_hw_reg;
    logic [INTERVAL_BITS-1:0] interval_reg;

    // Running state of the frames.
    logic signed [COORD_BITS-1:0] cur_min_reg, prev_min_reg;
    logic                         cur_found_reg, prev_found_reg, seen_reg;

    // Values frozen at a frame end.
    logic signed [COORD_BITS-1:0] snap_cur_reg, snap_prev_reg;
    logic                         snap_seen_reg, snap_cur_found_reg, snap_prev_found_reg;

    // Divider.
    logic [NMAG-1:0]        dq_reg;
    logic [DMAG-1:0]        rem_reg, dvs_reg;
    logic                   q_neg_reg;
    logic [STATUS_BITS-1:0] res_status_reg;

    // Result register.
    logic [TTC_BITS-1:0]    ttc_reg;
    logic [STATUS_BITS-1:0] out_status_reg;

    logic signed [CMPW-1:0]       lat_ext, hw_pos, hw_neg;
    logic                         in_lane, take_min;
    logic signed [COORD_BITS-1:0] cur_min_new;
    logic                         cur_found_new;

    logic signed [COORD_BITS:0] diff;
    logic                       diff_neg, cur_neg;
    logic [COORD_BITS-1:0]      cur_abs, diff_abs;
    logic [NMAG-1:0]            prod;
    logic [STATUS_BITS-1:0]     status_new;

    logic [DMAG:0]          rem_sh, rem_sub;
    logic                   q_bit;
    logic [SATW-1:0]        mag_ext;
    logic [TTC_BITS-1:0]    ttc_new;

    // A point counts when its lateral offset lies strictly inside the lane.
    always_comb
    begin
        lat_ext       = CMPW'(lateral_mm);
        hw_pos        = signed'(CMPW'(lane_hw_reg));
        hw_neg        = -hw_pos;
        in_lane       = (lat_ext < hw_pos) && (lat_ext > hw_neg);
        take_min      = in_lane && (!cur_found_reg || (forward_mm < cur_min_reg));
        cur_min_new   = take_min ? forward_mm : cur_min_reg;
        cur_found_new = cur_found_reg || in_lane;
    end

    // Sign and magnitude of both division operands.
    always_comb
    begin
        diff     = (COORD_BITS+1)'(snap_prev_reg) - (COORD_BITS+1)'(snap_cur_reg);
        diff_neg = diff[COORD_BITS];
        diff_abs = diff_neg ? COORD_BITS'(-diff) : COORD_BITS'(diff);
        cur_neg  = snap_cur_reg[COORD_BITS-1];
        cur_abs  = cur_neg ? (~snap_cur_reg + COORD_BITS'(1)) : snap_cur_reg;
        prod     = NMAG'(cur_abs) * NMAG'(interval_reg);

        if (!snap_seen_reg)
        begin
            status_new = STATUS_NO_PREV;
        end
        else if (!snap_cur_found_reg || !snap_prev_found_reg)
        begin
            status_new = STATUS_NO_LANE;
        end
        else if (diff == '0)
        begin
            status_new = STATUS_ZERO_CLOSE;
        end
        else
        begin
            status_new = STATUS_OK;
        end
        stat.need_div = (status_new == STATUS_OK);
    end

    // One quotient bit per cycle.
    always_comb
    begin
        rem_sh  = {rem_reg, dq_reg[NMAG-1]};
        rem_sub = rem_sh - {1'b0, dvs_reg};
        q_bit   = rem_sh >= {1'b0, dvs_reg};
    end

    always_comb
    begin
        mag_ext = SATW'(dq_reg);
        if (res_status_reg != STATUS_OK)
        begin
            ttc_new = '0;
        end
        else if (q_neg_reg)
        begin
            ttc_new = (mag_ext > SATW'(TTC_NEG_MAG)) ? TTC_NEG_LIMIT
                                                     : (~mag_ext[TTC_BITS-1:0] + 32'd1);
        end
        else
        begin
            ttc_new = (mag_ext > SATW'(TTC_POS_MAG)) ? TTC_POS_LIMIT
                                                     : mag_ext[TTC_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_hw_reg    <= LANE_RESET;
            interval_reg   <= INTERVAL_RESET;
            cur_min_reg    <= COORD_MAX;
            prev_min_reg   <= COORD_MAX;
            cur_found_reg  <= 1'b0;
            prev_found_reg <= 1'b0;
            seen_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == REG_LANE_HALF_WIDTH))
            begin
                lane_hw_reg <= cfg_data[LANE_BITS-1:0];
            end
            if (cfg_we && (cfg_index == REG_FRAME_INTERVAL))
            begin
                interval_reg <= cfg_data[INTERVAL_BITS-1:0];
            end

            if (cmd.frame_close)
            begin
                prev_min_reg   <= cur_min_new;
                prev_found_reg <= cur_found_new;
                seen_reg       <= 1'b1;
                cur_min_reg    <= COORD_MAX;
                cur_found_reg  <= 1'b0;
            end
            else if (cmd.take_point)
            begin
                cur_min_reg   <= cur_min_new;
                cur_found_reg <= cur_found_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.frame_close)
        begin
            snap_cur_reg        <= cur_min_new;
            snap_prev_reg       <= prev_min_reg;
            snap_seen_reg       <= seen_reg;
            snap_cur_found_reg  <= cur_found_new;
            snap_prev_found_reg <= prev_found_reg;
        end

        if (cmd.mul_load)
        begin
            dq_reg         <= prod;
            rem_reg        <= '0;
            dvs_reg        <= diff_abs;
            q_neg_reg      <= cur_neg ^ diff_neg;
            res_status_reg <= status_new;
        end
        else if (cmd.div_step)
        begin
            dq_reg  <= {dq_reg[NMAG-2:0], q_bit};
            rem_reg <= q_bit ? rem_sub[DMAG-1:0] : rem_sh[DMAG-1:0];
        end

        if (cmd.out_load)
        begin
            ttc_reg        <= ttc_new;
            out_status_reg <= res_status_reg;
        end
    end

    assign ttc_us = signed'(ttc_reg);
    assign status = out_status_reg;

endmodule
`default_nettype wire

// File: design/lidar_lane_min_time_to_collision.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lidar_lane_min_time_to_collision
// Tracks the nearest in-lane lidar point of each frame and reports the
// time to collision against the previous frame at every frame end.
//
//   Channel | Handshake            | Beat contents
//   --------+----------------------+-----------------------------------------
//   cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//   in      | in_valid/in_ready    | forward_mm, lateral_mm, frame_end
//   out     | out_valid/out_ready  | ttc_us, status
//
// A point that does not end a frame leaves the input open.
// A frame end point holds in_ready low through a multiply state, a
// restoring divider giving one quotient bit per cycle when a division is
// needed, then a load state that waits until the result register is free.
// The result register lets points flow while a result waits; after a
// following frame end the input stays closed until that result has been taken.
// Reset is asynchronous and active low; configuration is always accepted.
// ----------------------------------------------------------------------------
module lidar_lane_min_time_to_collision #(
    parameter int COORD_BITS = 18
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [llttc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [llttc_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [COORD_BITS-1:0]            forward_mm,
    input  logic signed [COORD_BITS-1:0]            lateral_mm,
    input  logic                                    frame_end,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [llttc_pkg::TTC_BITS-1:0]   ttc_us,
    output logic [llttc_pkg::STATUS_BITS-1:0]       status
);
    import llttc_pkg::*;

    localparam int DIV_STEPS = COORD_BITS + INTERVAL_BITS - 1;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    llttc_ctrl #(
        .DIV_STEPS (DIV_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .frame_end (frame_end),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .stat      (stat),
        .cmd       (cmd)
    );

    llttc_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_we     (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .forward_mm (forward_mm),
        .lateral_mm (lateral_mm),
        .ttc_us     (ttc_us),
        .status     (status)
    );

endmodule
`default_nettype wire

// File: design/llttc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llttc_checker
// Port-level checks on the time-to-collision block, bound to the top level.
// ----------------------------------------------------------------------------
module llttc_checker #(
    parameter int COORD_BITS = 18
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    input  logic                                    in_ready,
    input  logic signed [COORD_BITS-1:0]            forward_mm,
    input  logic signed [COORD_BITS-1:0]            lateral_mm,
    input  logic                                    frame_end,
    input  logic                                    out_valid,
    input  logic                                    out_ready,
    input  logic signed [llttc_pkg::TTC_BITS-1:0]   ttc_us,
    input  logic [llttc_pkg::STATUS_BITS-1:0]       status
);
    import llttc_pkg::*;

    // A point that is offered but not taken stays on the port unchanged.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_ready) |=> (in_valid && $stable(forward_mm)
                                     && $stable(lateral_mm) && $stable(frame_end)))
        else $error("input beat changed while stalled");

    // A result that is not taken holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(ttc_us) && $stable(status)))
        else $error("result changed while stalled");

    // A frame end beat always starts the computation, so the input closes.
    a_frame_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && frame_end) |=> !in_ready)
        else $error("input still open after a frame end beat");

    // A point inside a frame never produces a result.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !frame_end) |=> !$rose(out_valid))
        else $error("result appeared after a point that does not end a frame");

    // Every status other than ok carries a zero time.
    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != STATUS_OK)) |-> (ttc_us == '0))
        else $error("non-zero time with a flagged status");

endmodule

bind lidar_lane_min_time_to_collision llttc_checker #(
    .COORD_BITS (COORD_BITS)
) u_llttc_checker (.*);
`default_nettype wire
